@@ hw/rtl/mma_pkg.sv @@
// Shared types, codes and defaults for the matrix multiply-accumulate core.
package mma_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // Widths fixed by the channel fields and the register map.
  localparam int VALUE_W   = 32;
  localparam int OPCODE_W  = 3;
  localparam int INDEX_W   = 3;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_BITS = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

  typedef enum logic [OPCODE_W-1:0] {
    OP_WR_A = 3'd0,
    OP_WR_B = 3'd1,
    OP_WR_C = 3'd2,
    OP_MUL  = 3'd3,
    OP_RD_C = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A     = 2'd0,
    CFG_INNER_LEN  = 2'd1,
    CFG_COLS_B     = 2'd2,
    CFG_ACCUMULATE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_SAT,
    ST_WB
  } state_t;

endpackage

@@ hw/rtl/matrix_multiply_accumulate_core.sv @@
// Matrix multiply-accumulate core: element stores for A, B, C and a shared MAC sequencer.
//
// Usage. Items enter on the in_ channel (valid/ready) and carry an opcode: write an
// element of A, B or C, start a multiply, or read an element of C. Writes outside the
// active region set by rows_a, inner_len and cols_b are dropped. A multiply and a read
// each return one result on the out_ channel (valid/ready); writes return nothing.
// The size and accumulate registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the core is idle, which the core does not enforce.
// Timing. A read passes through the read register of the C store and then the output
// register; an out-of-range read goes straight to the output register. A multiply runs
// one shared multiplier and accumulator over every dot product: the elements of C are
// worked out one at a time, and the terms of each pass in order through the single
// read port of each store.
// The core takes one item at a time and holds in_ready low while it works.
// Reset. After rst_n the core sweeps all MAX_DIM*MAX_DIM entries of C (64 by default)
// to zero, one entry a cycle, before it takes an item; configuration writes are taken then.
// Stall. A finished result sits in the output register until it is taken; the next item
// is accepted in the same cycle as that transfer.
module matrix_multiply_accumulate_core #(
  parameter int MAX_DIM    = mma_pkg::MAX_DIM_DEF,
  parameter int DATA_WIDTH = mma_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mma_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [mma_pkg::INDEX_W-1:0]        in_row_index,
  input  logic [mma_pkg::INDEX_W-1:0]        in_col_index,
  input  logic signed [mma_pkg::VALUE_W-1:0] in_element_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [mma_pkg::VALUE_W-1:0] out_read_value,
  output logic                               out_multiply_done,
  output logic                               out_index_error,
  input  logic                               cfg_we,
  input  logic [mma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mma_pkg::DIM_W-1:0]          cfg_wdata
);
  import mma_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W = 2 * DW + DIM_W;
  localparam int DIM_MAX_REG = (1 << DIM_W) - 1;
  localparam logic [DIM_W-1:0] DIM_CAP =
    DIM_W'((MAX_DIM > DIM_MAX_REG) ? DIM_MAX_REG : MAX_DIM);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic signed [ACC_W-1:0] ACC_HI = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0]    D_HI   = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0]    D_LO   = {1'b1, {(DW-1){1'b0}}};

  function automatic logic [AW-1:0] addr_of(input logic [DIM_W-1:0] row,
                                            input logic [DIM_W-1:0] col);
    int t;
    t = int'(row) * MAX_DIM + int'(col);
    return AW'(t);
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0] rows_a_r, inner_len_r, cols_b_r;
  logic             accum_r;
  logic [DIM_W-1:0] nr, nk, nc;

  // Sequencer and datapath registers.
  state_t                   state_r, state_nxt;
  logic [AW-1:0]            clr_addr_r, clr_addr_nxt;
  logic [DIM_W-1:0]         i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic                     rd_v_r, rd_v_nxt, mul_v_r, mul_v_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, acc_sh;
  logic signed [2*DW-1:0]   prod_r;
  logic signed [DW-1:0]     dot_r, dot_nxt;
  logic signed [DW:0]       c_sum;
  logic signed [DW-1:0]     c_acc;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                     out_done_r, out_done_nxt, out_err_r, out_err_nxt;

  // Element stores.
  logic signed [DW-1:0] mem_a [DEPTH];
  logic signed [DW-1:0] mem_b [DEPTH];
  logic signed [DW-1:0] mem_c [DEPTH];
  logic signed [DW-1:0] a_q, b_q, c_q;
  logic                 a_we, b_we, c_we, c_re;
  logic [AW-1:0]        a_waddr, b_waddr, c_waddr, a_raddr, b_raddr, c_raddr;
  logic signed [DW-1:0] c_wdata, in_val;

  logic [DIM_W-1:0] in_row, in_col;
  logic             xfer;

  assign nr = (rows_a_r    > DIM_CAP) ? DIM_CAP : rows_a_r;
  assign nk = (inner_len_r > DIM_CAP) ? DIM_CAP : inner_len_r;
  assign nc = (cols_b_r    > DIM_CAP) ? DIM_CAP : cols_b_r;

  assign in_row = DIM_W'(in_row_index);
  assign in_col = DIM_W'(in_col_index);
  assign in_val = in_element_value[DW-1:0];

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign xfer     = in_valid && in_ready;

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_value_r;
  assign out_multiply_done = out_done_r;
  assign out_index_error   = out_err_r;

  // Floor shift back to Q16.16 and saturating add into C.
  assign acc_sh = acc_r >>> FRAC_BITS;
  assign c_sum  = (DW+1)'(c_q) + (DW+1)'(dot_r);
  assign c_acc  = (c_sum[DW] != c_sum[DW-1]) ? (c_sum[DW] ? D_LO : D_HI) : c_sum[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIM_RESET;
      inner_len_r <= DIM_RESET;
      cols_b_r    <= DIM_RESET;
      accum_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROWS_A:     rows_a_r    <= cfg_wdata;
        CFG_INNER_LEN:  inner_len_r <= cfg_wdata;
        CFG_COLS_B:     cols_b_r    <= cfg_wdata;
        CFG_ACCUMULATE: accum_r     <= cfg_wdata[0];
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    rd_v_nxt      = 1'b0;
    mul_v_nxt     = 1'b0;
    acc_nxt       = acc_r;
    dot_nxt       = dot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_done_nxt  = out_done_r;
    out_err_nxt   = out_err_r;
    a_we          = 1'b0;
    b_we          = 1'b0;
    c_we          = 1'b0;
    c_re          = 1'b0;
    a_waddr       = addr_of(in_row, in_col);
    b_waddr       = addr_of(in_row, in_col);
    c_waddr       = addr_of(in_row, in_col);
    c_wdata       = in_val;
    a_raddr       = addr_of(i_r, k_r);
    b_raddr       = addr_of(k_r, j_r);
    c_raddr       = addr_of(i_r, j_r);

    unique case (state_r)
      ST_CLEAR: begin
        c_we         = 1'b1;
        c_waddr      = clr_addr_r;
        c_wdata      = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (xfer) begin
          case (in_opcode)
            OP_WR_A: a_we = (in_row < nr) && (in_col < nk);
            OP_WR_B: b_we = (in_row < nk) && (in_col < nc);
            OP_WR_C: c_we = (in_row < nr) && (in_col < nc);
            OP_MUL: begin
              if ((nr == '0) || (nc == '0)) begin
                out_valid_nxt = 1'b1;
                out_value_nxt = '0;
                out_done_nxt  = 1'b1;
                out_err_nxt   = 1'b0;
              end else begin
                i_nxt     = '0;
                j_nxt     = '0;
                k_nxt     = '0;
                acc_nxt   = '0;
                state_nxt = ST_MAC;
              end
            end
            OP_RD_C: begin
              if ((in_row < nr) && (in_col < nc)) begin
                c_re      = 1'b1;
                c_raddr   = addr_of(in_row, in_col);
                state_nxt = ST_READ;
              end else begin
                out_valid_nxt = 1'b1;
                out_value_nxt = '0;
                out_done_nxt  = 1'b0;
                out_err_nxt   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = VALUE_W'(c_q);
        out_done_nxt  = 1'b0;
        out_err_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end

      ST_MAC: begin
        // Reads issue one term a cycle; each term then passes through the store read
        // registers and the product register prod_r into the running sum acc_r.
        c_re = 1'b1;
        if (k_r < nk) begin
          k_nxt    = k_r + DIM_W'(1);
          rd_v_nxt = 1'b1;
        end
        mul_v_nxt = rd_v_r;
        if (mul_v_r) begin
          acc_nxt = acc_r + ACC_W'(prod_r);
        end
        if ((k_r == nk) && !rd_v_r && !mul_v_r) begin
          state_nxt = ST_SAT;
        end
      end

      ST_SAT: begin
        if (acc_sh > ACC_HI) begin
          dot_nxt = D_HI;
        end else if (acc_sh < ACC_LO) begin
          dot_nxt = D_LO;
        end else begin
          dot_nxt = acc_sh[DW-1:0];
        end
        state_nxt = ST_WB;
      end

      ST_WB: begin
        c_we    = 1'b1;
        c_waddr = addr_of(i_r, j_r);
        c_wdata = accum_r ? c_acc : dot_r;
        acc_nxt = '0;
        k_nxt   = '0;
        state_nxt = ST_MAC;
        if (j_r + DIM_W'(1) == nc) begin
          j_nxt = '0;
          if (i_r + DIM_W'(1) == nr) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_done_nxt  = 1'b1;
            out_err_nxt   = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            i_nxt = i_r + DIM_W'(1);
          end
        end else begin
          j_nxt = j_r + DIM_W'(1);
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      rd_v_r      <= rd_v_nxt;
      mul_v_r     <= mul_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    dot_r       <= dot_nxt;
    prod_r      <= a_q * b_q;
    out_value_r <= out_value_nxt;
    out_done_r  <= out_done_nxt;
    out_err_r   <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[a_waddr] <= in_val;
    end
    a_q <= mem_a[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem_b[b_waddr] <= in_val;
    end
    b_q <= mem_b[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      mem_c[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_q <= mem_c[c_raddr];
    end
  end

endmodule

@@ bench/tb_matrix_multiply_accumulate_core.sv @@
// Self-checking testbench for the matrix multiply-accumulate core.
`timescale 1ns / 1ps

module tb_matrix_multiply_accumulate_core;
  import mma_pkg::*;

  localparam int DIM         = MAX_DIM_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 4;
  localparam int TAIL        = 30;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 96;

  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [VALUE_W-1:0] Q_TOP = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] Q_BOT = 32'h8000_0000;
  localparam logic signed [127:0] WIDE_TOP = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] WIDE_BOT = -128'sh8000_0000;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [INDEX_W-1:0]  row;
    logic [INDEX_W-1:0]  col;
    logic [VALUE_W-1:0]  value;
  } mma_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      done;
    logic                      idx_err;
  } c_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OPCODE_W-1:0]       in_opcode = OP_WR_A;
  logic [INDEX_W-1:0]        in_row_index = '0;
  logic [INDEX_W-1:0]        in_col_index = '0;
  logic signed [VALUE_W-1:0] in_element_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_read_value;
  logic                      out_multiply_done;
  logic                      out_index_error;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [DIM_W-1:0]          cfg_wdata;

  matrix_multiply_accumulate_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_multiply_done (out_multiply_done),
    .out_index_error   (out_index_error),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  mma_cmd_t  cmd_q[$];
  c_result_t gemm_results_q[$];

  // Shadow copy of the core's stores and size registers.
  logic signed [VALUE_W-1:0] mat_a [DIM*DIM];
  logic signed [VALUE_W-1:0] mat_b [DIM*DIM];
  logic signed [VALUE_W-1:0] mat_c [DIM*DIM];
  logic [DIM_W-1:0]          p_rows = DIM_RESET;
  logic [DIM_W-1:0]          p_inner = DIM_RESET;
  logic [DIM_W-1:0]          p_cols = DIM_RESET;
  logic                      p_acc = 1'b0;

  // Generator view: sizes in force and which operand entries hold data.
  int g_rows = DIM;
  int g_inner = DIM;
  int g_cols = DIM;
  bit a_known [DIM*DIM];
  bit b_known [DIM*DIM];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  cycle_count = 0;
  int  errors = 0;
  int  n_in, n_checked, n_mul, n_rd, n_oob, n_settings;
  logic in_took = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int clip_dim(input int v);
    return (v > DIM) ? DIM : v;
  endfunction

  function automatic logic signed [VALUE_W-1:0] to_q16(input logic signed [127:0] x);
    if (x > WIDE_TOP) return Q_TOP;
    if (x < WIDE_BOT) return Q_BOT;
    return x[VALUE_W-1:0];
  endfunction

  task automatic gemm_apply(input logic [OPCODE_W-1:0] op, input int r, input int c,
                            input logic signed [VALUE_W-1:0] v);
    int nr, nk, nc;
    logic signed [127:0] acc, wide, ea, eb;
    logic signed [VALUE_W-1:0] dsat;
    c_result_t res;
    nr = clip_dim(int'(p_rows));
    nk = clip_dim(int'(p_inner));
    nc = clip_dim(int'(p_cols));
    res = '0;
    case (op)
      OP_WR_A: if (r < nr && c < nk) mat_a[r*DIM+c] = v;
      OP_WR_B: if (r < nk && c < nc) mat_b[r*DIM+c] = v;
      OP_WR_C: if (r < nr && c < nc) mat_c[r*DIM+c] = v;
      OP_MUL: begin
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = '0;
            for (int k = 0; k < nk; k++) begin
              ea = 128'(mat_a[i*DIM+k]);
              eb = 128'(mat_b[k*DIM+j]);
              acc += ea * eb;
            end
            // Arithmetic shift gives floor rounding back to Q16.16.
            dsat = to_q16(acc >>> FRAC_BITS);
            if (p_acc) begin
              wide = 128'(mat_c[i*DIM+j]);
              wide += 128'(dsat);
              dsat = to_q16(wide);
            end
            mat_c[i*DIM+j] = dsat;
          end
        end
        res.done = 1'b1;
        gemm_results_q.push_back(res);
        n_mul++;
      end
      OP_RD_C: begin
        if (r < nr && c < nc) begin
          res.value = mat_c[r*DIM+c];
        end else begin
          res.idx_err = 1'b1;
          n_oob++;
        end
        gemm_results_q.push_back(res);
        n_rd++;
      end
      default: ;
    endcase
  endtask

  // Sampling side: result checks, register shadowing and prediction.
  always @(posedge clk) begin : observe
    c_result_t want;
    cycle_count <= cycle_count + 1;
    in_took <= in_valid && in_ready;
    if (!rst_n) begin
      for (int i = 0; i < DIM*DIM; i++) begin
        mat_a[i] = '0;
        mat_b[i] = '0;
        mat_c[i] = '0;
      end
    end
    if (rst_n && out_valid && out_ready) begin
      if (gemm_results_q.size() == 0) begin
        errors++;
        $display("%0t: result with none pending: value %h done %b err %b", $time,
                 out_read_value, out_multiply_done, out_index_error);
      end else begin
        want = gemm_results_q.pop_front();
        n_checked++;
        if (out_read_value !== want.value) begin
          errors++;
          $display("%0t: read_value expected %h actual %h", $time, want.value,
                   out_read_value);
        end
        if (out_multiply_done !== want.done) begin
          errors++;
          $display("%0t: multiply_done expected %b actual %b", $time, want.done,
                   out_multiply_done);
        end
        if (out_index_error !== want.idx_err) begin
          errors++;
          $display("%0t: index_error expected %b actual %b", $time, want.idx_err,
                   out_index_error);
        end
      end
    end
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_ROWS_A:     p_rows = cfg_wdata;
        CFG_INNER_LEN:  p_inner = cfg_wdata;
        CFG_COLS_B:     p_cols = cfg_wdata;
        CFG_ACCUMULATE: p_acc = cfg_wdata[0];
        default: ;
      endcase
    end
    if (rst_n && in_valid && in_ready) begin
      n_in++;
      gemm_apply(in_opcode, int'(in_row_index), int'(in_col_index), in_element_value);
    end
  end

  // Driving side: the input channel and the receiver's backpressure.
  always @(negedge clk) begin : drive
    mma_cmd_t cmd;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!in_valid || in_took) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd = cmd_q.pop_front();
        in_valid         <= 1'b1;
        in_opcode        <= cmd.op;
        in_row_index     <= cmd.row;
        in_col_index     <= cmd.col;
        in_element_value <= cmd.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic bit lands(input logic [OPCODE_W-1:0] op, input int r, input int c);
    case (op)
      OP_WR_A: return r < g_rows && c < g_inner;
      OP_WR_B: return r < g_inner && c < g_cols;
      OP_WR_C: return r < g_rows && c < g_cols;
      OP_MUL, OP_RD_C: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_cmd(input logic [OPCODE_W-1:0] op, input int r, input int c,
                          input logic [VALUE_W-1:0] v);
    mma_cmd_t cmd;
    cmd.op    = op;
    cmd.row   = r[INDEX_W-1:0];
    cmd.col   = c[INDEX_W-1:0];
    cmd.value = v;
    if (lands(op, r, c) && op == OP_WR_A) a_known[r*DIM+c] = 1'b1;
    if (lands(op, r, c) && op == OP_WR_B) b_known[r*DIM+c] = 1'b1;
    cmd_q.push_back(cmd);
  endtask

  function automatic logic [VALUE_W-1:0] rand_q16();
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(4))
          0: return Q_TOP;
          1: return Q_BOT;
          2: return '0;
          3: return '1;
          default: return 32'h0000_0001;
        endcase
      end
      2, 3, 4, 5: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_index(input int n);
    if (n > 0 && $urandom_range(1)) return $urandom_range(n - 1);
    return $urandom_range(DIM - 1);
  endfunction

  // A multiply must never touch an operand entry that was never written.
  task automatic fill_operands();
    for (int r = 0; r < g_rows; r++)
      for (int c = 0; c < g_inner; c++)
        if (!a_known[r*DIM+c]) push_cmd(OP_WR_A, r, c, rand_q16());
    for (int r = 0; r < g_inner; r++)
      for (int c = 0; c < g_cols; c++)
        if (!b_known[r*DIM+c]) push_cmd(OP_WR_B, r, c, rand_q16());
  endtask

  task automatic run_random(input int n);
    int count, p, r, c;
    logic [OPCODE_W-1:0] op;
    count = 0;
    while (count < n) begin
      p = $urandom_range(99);
      if (p < 18) begin
        op = OP_WR_A;
        r = pick_index(g_rows);
        c = pick_index(g_inner);
      end else if (p < 36) begin
        op = OP_WR_B;
        r = pick_index(g_inner);
        c = pick_index(g_cols);
      end else begin
        if (p < 46) op = OP_WR_C;
        else if (p < 78) op = OP_RD_C;
        else if (p < 90) op = OP_MUL;
        else op = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        r = pick_index(g_rows);
        c = pick_index(g_cols);
      end
      if (op == OP_MUL) fill_operands();
      count++;
      push_cmd(op, r, c, rand_q16());
    end
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_valid || gemm_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_sizes(input int rows, input int inner, input int cols, input int acc);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS_A;
    cfg_wdata <= DIM_W'(rows);
    @(negedge clk);
    cfg_index <= CFG_INNER_LEN;
    cfg_wdata <= DIM_W'(inner);
    @(negedge clk);
    cfg_index <= CFG_COLS_B;
    cfg_wdata <= DIM_W'(cols);
    @(negedge clk);
    cfg_index <= CFG_ACCUMULATE;
    cfg_wdata <= DIM_W'(acc);
    @(negedge clk);
    cfg_we <= 1'b0;
    g_rows  = clip_dim(rows);
    g_inner = clip_dim(inner);
    g_cols  = clip_dim(cols);
    n_settings++;
  endtask

  task automatic set_idling(input int phase);
    case (phase * 3 / PHASES)
      0: begin
        send_idle_pct = 11;
        recv_idle_pct = 45;
      end
      1: begin
        send_idle_pct = 45;
        recv_idle_pct = 11;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Size settings as nibbles: rows, inner, cols, accumulate. Zero sizes and
  // sizes above MAX_DIM are among them.
  function automatic logic [15:0] phase_setting(input int p);
    case (p)
      0: return 16'h2320;
      1: return 16'h8881;
      2: return 16'h0430;
      3: return 16'h3041;
      4: return 16'h4500;
      5: return 16'hFFF1;
      6: return 16'h1111;
      7: return 16'h3250;
      8: return 16'h8180;
      9: return 16'h5831;
      default: return {4'($urandom), 4'($urandom), 4'($urandom), 3'b000, 1'($urandom)};
    endcase
  endfunction

  initial begin : stimulus
    logic [15:0] s;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_ROWS_A;
    cfg_wdata        = '0;
    set_idling(0);
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // C corners at the value extremes, a C entry untouched since reset,
    // and the spare opcodes, one of them with every field bit set.
    push_cmd(OP_WR_C, 0, 0, Q_TOP);
    push_cmd(OP_WR_C, 7, 7, Q_BOT);
    push_cmd(OP_RD_C, 0, 0, '0);
    push_cmd(OP_RD_C, 7, 7, '1);
    push_cmd(OP_RD_C, 3, 4, '0);
    push_cmd(OP_SPARE_LO, 7, 7, '1);
    push_cmd(OPCODE_W'(OP_SPARE_LO + 1), 0, 0, '0);
    push_cmd(OP_SPARE_HI, 5, 2, Q_BOT);

    // A one-element result from a two-term dot product that overflows.
    set_sizes(1, 2, 1, 0);
    push_cmd(OP_WR_A, 0, 0, Q_TOP);
    push_cmd(OP_WR_A, 0, 1, Q_TOP);
    push_cmd(OP_WR_B, 0, 0, Q_TOP);
    push_cmd(OP_WR_B, 1, 0, Q_TOP);
    push_cmd(OP_WR_A, 1, 0, 32'h0000_0005);
    push_cmd(OP_MUL, 0, 0, '0);
    push_cmd(OP_RD_C, 0, 0, '0);
    push_cmd(OP_RD_C, 0, 1, '0);
    push_cmd(OP_RD_C, 1, 0, '0);

    // Accumulate with a product that saturates low, twice.
    set_sizes(1, 2, 1, 1);
    push_cmd(OP_WR_A, 0, 0, Q_BOT);
    push_cmd(OP_WR_A, 0, 1, Q_BOT);
    push_cmd(OP_MUL, 0, 0, '0);
    push_cmd(OP_RD_C, 0, 0, '0);
    push_cmd(OP_MUL, 0, 0, '0);
    push_cmd(OP_RD_C, 0, 0, '0);

    for (int p = 0; p < PHASES; p++) begin
      s = phase_setting(p);
      set_idling(p);
      set_sizes(int'(s[15:12]), int'(s[11:8]), int'(s[7:4]), int'(s[3:0]));
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (TAIL) @(posedge clk);
    $display("Sent %0d items over %0d size settings; checked %0d results.", n_in,
             n_settings, n_checked);
    $display("That took in %0d multiplies and %0d reads of C, %0d of them out of range.",
             n_mul, n_rd, n_oob);
    if (errors == 0) begin
      $display("tb_matrix_multiply_accumulate_core: PASS");
    end else begin
      $display("tb_matrix_multiply_accumulate_core: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
             gemm_results_q.size());
    $display("tb_matrix_multiply_accumulate_core: FAIL");
    $finish;
  end

endmodule
